/* rtl/dwsp_pkg.sv */
// ----------------------------------------------------------------------------
// dwsp_pkg: shared constants for the dual wheel speed controller
// Register indexes, reset values, widths and limits.
// ----------------------------------------------------------------------------
package dwsp_pkg;

  localparam int LEFT_INIT_DUTY  = 500;
  localparam int RIGHT_INIT_DUTY = 450;
  localparam int SUM_LIMIT       = 50;
  localparam int SPEED_BITS      = 16;

  localparam int DUTY_W  = 10;
  localparam int GAIN_W  = 10;
  localparam int REG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int PULSE_W = 16;
  localparam int DUTY_MAX = 1000;
  localparam int DUTY_SCALE = 20000;

  localparam logic [IDX_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LEFT_KP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_LEFT_KI  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LEFT_KD  = 3'd3;
  localparam logic [IDX_W-1:0] REG_RIGHT_KP = 3'd4;
  localparam logic [IDX_W-1:0] REG_RIGHT_KI = 3'd5;
  localparam logic [IDX_W-1:0] REG_RIGHT_KD = 3'd6;
  localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd7;

endpackage

/* rtl/dwsp_serial_mac.sv */
// ----------------------------------------------------------------------------
// dwsp_serial_mac: bit-serial multiply-accumulate
// Adds a * b to an accumulator, one multiplier bit per cycle (shift and add).
// ----------------------------------------------------------------------------
module dwsp_serial_mac #(
  parameter int AW = 48,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic        [BW-1:0] b,
  input  logic signed [AW-1:0] acc_in,
  output logic                 done,
  output logic signed [AW-1:0] acc_out
);
  import dwsp_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0] a_r, acc_r;
  logic        [BW-1:0] b_r;
  logic        [CW-1:0] cnt_r;
  logic                 busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a;
        b_r    <= b;
        acc_r  <= acc_in;
      end else if (busy_r) begin
        if (b_r[0]) acc_r <= acc_r + a_r;
        a_r   <= a_r <<< 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign acc_out = acc_r;

endmodule

/* rtl/dual_wheel_speed_pid.sv */
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid: two-wheel incremental pid speed loop
// Per control period updates each enabled wheel's duty and reports pulses.
// ----------------------------------------------------------------------------
// usage:
//   in_ word: both measured speeds, per-wheel enables and a reload flag.
//   out_ word: the pulse width and duty of both wheels after the update.
//   cfg_ channel writes target, gains and pwm period, only while idle.
// one word is processed at a time through a single bit-serial mac:
//   for each enabled wheel three products (kp, ki, kd terms, 17 bits each),
//   one restoring division by 20000 (1 bit per cycle), and for each wheel
//   one pulse product plus division by 1000.
// the result sits in an output register; in_tready is low until it is
// taken, so a stalled receiver stalls the input side.
// reset: gains, target and period take their defaults, error history and
// sums clear, duties load the initial values.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pid #(
  parameter int LEFT_INIT  = dwsp_pkg::LEFT_INIT_DUTY,
  parameter int RIGHT_INIT = dwsp_pkg::RIGHT_INIT_DUTY,
  parameter int SUM_LIM    = dwsp_pkg::SUM_LIMIT,
  parameter int SPEED_W    = dwsp_pkg::SPEED_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // left_speed, right_speed
  input  logic [2*SPEED_W-1:0]    in_tdata,
  // left_enable, right_enable, reload
  input  logic [2:0]              in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // left_pulse, right_pulse, left_duty, right_duty, zero fill
  output logic [55:0]             out_tdata,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [dwsp_pkg::IDX_W-1:0] cfg_index,
  input  logic [dwsp_pkg::REG_W-1:0] cfg_data
);
  import dwsp_pkg::*;

  localparam int EW = (SPEED_W > REG_W ? SPEED_W : REG_W) + 1;
  localparam int AW = EW + 30;
  localparam int SW = $clog2(SUM_LIM + 1) + 2;
  localparam int DCW = $clog2(AW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_MP, S_MI, S_MD, S_WAIT, S_DIV, S_FIN, S_PUL, S_PDIV, S_OUT
  } state_t;

  state_t state_r;
  logic [REG_W-1:0] target_r, period_r;
  logic [GAIN_W-1:0] kp_r [2], ki_r [2], kd_r [2];
  logic signed [EW-1:0] prev_r [2], prev2_r [2];
  logic signed [SW-1:0] sum_r [2];
  logic [DUTY_W-1:0] duty_r [2];
  logic [SPEED_W-1:0] spd_r [2];
  logic [1:0] en_r;
  logic wh_r;
  logic signed [EW-1:0] e_r;
  logic [1:0] step_r;
  logic [PULSE_W-1:0] pulse_r [2];
  logic [55:0] odata_r;
  logic ovalid_r;

  // divider
  logic [AW-1:0] dq_r, drem_r;
  logic [DCW-1:0] dcnt_r;
  logic dneg_r;

  // mac
  logic mac_start;
  logic signed [AW-1:0] mac_a, mac_acc_in, mac_out;
  logic [EW-1:0] mac_b;
  logic mac_done;

  dwsp_serial_mac #(.AW(AW), .BW(EW)) u_mac (
    .clk(clk), .rst_n(rst_n), .start(mac_start), .a(mac_a), .b(mac_b),
    .acc_in(mac_acc_in), .done(mac_done), .acc_out(mac_out)
  );

  logic signed [EW:0] d1, d2;
  logic signed [EW+2:0] dsum;
  logic signed [AW-1:0] tot_s;
  logic [AW-1:0] tot_mag, rem_sh;
  logic signed [EW:0] sum_nx;
  logic [AW-1:0] qtmp;

  always_comb begin
    d1   = (EW+1)'(e_r) - (EW+1)'(prev_r[wh_r]);
    d2   = (EW+1)'(e_r) - (EW+1)'(prev2_r[wh_r]);
    dsum = (EW+3)'(d1) + ((EW+3)'(d2) <<< 1);
    tot_s = mac_out;
    tot_mag = tot_s[AW-1] ? AW'(-tot_s) : AW'(tot_s);
    rem_sh = {drem_r[AW-2:0], dq_r[AW-1]};
    sum_nx = (EW+1)'(sum_r[wh_r]) + (EW+1)'(e_r);
    qtmp = dq_r;
  end

  always_comb begin
    mac_start  = 1'b0;
    mac_a      = '0;
    mac_b      = '0;
    mac_acc_in = '0;
    case (state_r)
      S_ERR: begin
        mac_start  = 1'b1;
        mac_a      = AW'(20) * (e_r[EW-1] ? -AW'(e_r) : AW'(e_r));
        mac_b      = EW'(kp_r[wh_r]);
        mac_acc_in = AW'(DUTY_SCALE) * AW'(duty_r[wh_r]);
        if (e_r[EW-1]) mac_a = -mac_a;
      end
      S_MP: if (mac_done) begin
        mac_start  = 1'b1;
        mac_a      = AW'(sum_r[wh_r]);
        mac_b      = EW'(ki_r[wh_r]);
        mac_acc_in = mac_out;
      end
      S_MI: if (mac_done) begin
        mac_start  = 1'b1;
        mac_a      = AW'(dsum) * AW'(400);
        mac_b      = EW'(kd_r[wh_r]);
        mac_acc_in = mac_out;
      end
      S_PUL: begin
        mac_start  = 1'b1;
        mac_a      = AW'(duty_r[wh_r]);
        mac_b      = EW'(period_r);
        mac_acc_in = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      target_r <= REG_W'(200);
      kp_r[0] <= GAIN_W'(250); ki_r[0] <= GAIN_W'(20); kd_r[0] <= GAIN_W'(30);
      kp_r[1] <= GAIN_W'(230); ki_r[1] <= GAIN_W'(20); kd_r[1] <= GAIN_W'(30);
      period_r <= REG_W'(11362);
      for (int i = 0; i < 2; i++) begin
        prev_r[i] <= '0; prev2_r[i] <= '0; sum_r[i] <= '0;
      end
      duty_r[0] <= DUTY_W'(LEFT_INIT);
      duty_r[1] <= DUTY_W'(RIGHT_INIT);
      ovalid_r <= 1'b0;
      wh_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (cfg_valid && state_r == S_IDLE) begin
        case (cfg_index)
          REG_TARGET:   target_r <= cfg_data;
          REG_LEFT_KP:  kp_r[0] <= cfg_data[GAIN_W-1:0];
          REG_LEFT_KI:  ki_r[0] <= cfg_data[GAIN_W-1:0];
          REG_LEFT_KD:  kd_r[0] <= cfg_data[GAIN_W-1:0];
          REG_RIGHT_KP: kp_r[1] <= cfg_data[GAIN_W-1:0];
          REG_RIGHT_KI: ki_r[1] <= cfg_data[GAIN_W-1:0];
          REG_RIGHT_KD: kd_r[1] <= cfg_data[GAIN_W-1:0];
          REG_PERIOD:   period_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          spd_r[0] <= in_tdata[SPEED_W-1:0];
          spd_r[1] <= in_tdata[2*SPEED_W-1:SPEED_W];
          en_r     <= in_tuser[1:0];
          if (in_tuser[2]) begin
            duty_r[0] <= DUTY_W'(LEFT_INIT);
            duty_r[1] <= DUTY_W'(RIGHT_INIT);
          end
          wh_r    <= 1'b0;
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          // pick the next enabled wheel or go to pulse scaling
          if (en_r[wh_r]) begin
            e_r <= EW'(target_r) - EW'(spd_r[wh_r]);
            state_r <= S_ERR;
          end else if (!wh_r) begin
            wh_r <= 1'b1;
          end else begin
            wh_r <= 1'b0;
            state_r <= S_PUL;
          end
        end
        S_ERR: begin
          step_r  <= 2'd0;
          state_r <= S_MP;
        end
        S_MP: if (mac_done) state_r <= S_MI;
        S_MI: if (mac_done) state_r <= S_MD;
        S_MD: if (mac_done) begin
          drem_r <= '0;
          dcnt_r <= '0;
          if (step_r == 2'd0) begin
            dneg_r  <= tot_s[AW-1];
            dq_r    <= tot_mag;
            state_r <= S_DIV;
          end else begin
            dq_r    <= mac_out;
            state_r <= S_PDIV;
          end
        end
        S_DIV, S_PDIV: begin
          // restoring division, one quotient bit per cycle
          if (rem_sh >= AW'(state_r == S_DIV ? DUTY_SCALE : DUTY_MAX)) begin
            drem_r <= rem_sh - AW'(state_r == S_DIV ? DUTY_SCALE : DUTY_MAX);
            dq_r   <= {dq_r[AW-2:0], 1'b1};
          end else begin
            drem_r <= rem_sh;
            dq_r   <= {dq_r[AW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCW'(AW - 1))
            state_r <= (state_r == S_DIV) ? S_FIN : S_OUT;
        end
        S_FIN: begin
          if (dneg_r && qtmp != '0) duty_r[wh_r] <= '0;
          else if (qtmp > AW'(DUTY_MAX)) duty_r[wh_r] <= DUTY_W'(DUTY_MAX);
          else duty_r[wh_r] <= qtmp[DUTY_W-1:0];
          prev2_r[wh_r] <= prev_r[wh_r];
          prev_r[wh_r]  <= e_r;
          if (sum_nx > (EW+1)'(SUM_LIM)) sum_r[wh_r] <= SW'(SUM_LIM);
          else if (sum_nx < -(EW+1)'(SUM_LIM)) sum_r[wh_r] <= -SW'(SUM_LIM);
          else sum_r[wh_r] <= sum_nx[SW-1:0];
          en_r[wh_r] <= 1'b0;
          state_r <= S_WAIT;
        end
        S_PUL: begin
          step_r <= 2'd1;
          state_r <= S_MD;
        end
        default: ;
      endcase
      if (state_r == S_OUT) begin
        pulse_r[wh_r] <= dq_r[PULSE_W-1:0];
        if (!wh_r) begin
          wh_r <= 1'b1;
          state_r <= S_PUL;
        end else begin
          odata_r <= {4'd0, duty_r[1], duty_r[0], dq_r[PULSE_W-1:0], pulse_r[0]};
          ovalid_r <= 1'b1;
          wh_r <= 1'b0;
          state_r <= S_IDLE;
        end
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

/* tb/sv/dual_wheel_speed_pid_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid_tb: self-checking bench for the dual wheel pid block
// Drives control-period words, predicts duty and pulse per wheel, and checks
// every output word in order across several gain and target settings.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pid_tb;
  import dwsp_pkg::*;

  typedef struct {
    longint prev;
    longint prev2;
    longint acc;
    longint duty;
  } wheel_loop_t;

  typedef struct {
    logic [15:0] left_pulse;
    logic [15:0] right_pulse;
    logic [9:0]  left_duty;
    logic [9:0]  right_duty;
  } pid_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  // register copies, index order
  longint regs [8];
  wheel_loop_t left_loop, right_loop;
  pid_word_t expected_words [$];
  int fail_count = 0;
  int word_count = 0;
  int stall_mode = 0;
  int hold_cycles = 0;

  always #5 clk = ~clk;

  dual_wheel_speed_pid u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic void step_loop(ref wheel_loop_t w, input longint speed,
                                    input longint kp, input longint ki,
                                    input longint kd);
    longint e, d1, d2, q;
    e = regs[REG_TARGET] - speed;
    d1 = e - w.prev;
    d2 = e - w.prev2;
    w.prev2 = w.prev;
    w.prev = e;
    // sv division truncates toward zero
    q = (20000 * w.duty + 20 * kp * e + ki * w.acc + 400 * kd * (d1 + 2 * d2)) / 20000;
    if (q < 0) q = 0;
    if (q > DUTY_MAX) q = DUTY_MAX;
    w.duty = q;
    w.acc += e;
    if (w.acc > SUM_LIMIT) w.acc = SUM_LIMIT;
    if (w.acc < -SUM_LIMIT) w.acc = -SUM_LIMIT;
  endfunction

  function automatic logic [15:0] pulse_width(longint duty);
    longint p;
    p = (duty * regs[REG_PERIOD]) / 1000;
    return p[15:0];
  endfunction

  function automatic void predict_period(logic [15:0] ls, logic [15:0] rs,
                                         logic [2:0] flags);
    pid_word_t w;
    if (flags[2]) begin
      left_loop.duty = LEFT_INIT_DUTY;
      right_loop.duty = RIGHT_INIT_DUTY;
    end
    if (flags[0])
      step_loop(left_loop, ls, regs[REG_LEFT_KP], regs[REG_LEFT_KI], regs[REG_LEFT_KD]);
    if (flags[1])
      step_loop(right_loop, rs, regs[REG_RIGHT_KP], regs[REG_RIGHT_KI],
                regs[REG_RIGHT_KD]);
    w.left_pulse = pulse_width(left_loop.duty);
    w.right_pulse = pulse_width(right_loop.duty);
    w.left_duty = left_loop.duty[9:0];
    w.right_duty = right_loop.duty[9:0];
    expected_words.push_back(w);
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TARGET, REG_PERIOD: regs[idx] = val;
      default: regs[idx] = val[9:0];
    endcase
    @(posedge clk);
  endtask

  // sends one period word; gaps come in bursts, valid stays up inside a burst
  int burst_left = 0;
  task automatic send_period(logic [15:0] ls, logic [15:0] rs, logic [2:0] flags);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata <= {rs, ls};
    in_tuser <= flags;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_period(ls, rs, flags);
  endtask

  task automatic drain;
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    pid_word_t got, exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      got.left_pulse = out_tdata[15:0];
      got.right_pulse = out_tdata[31:16];
      got.left_duty = out_tdata[41:32];
      got.right_duty = out_tdata[51:42];
      word_count++;
      if (expected_words.size() == 0) begin
        $error("unexpected output word %h", out_tdata);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.left_pulse !== exp_w.left_pulse) begin
          $error("left_pulse exp %0d got %0d", exp_w.left_pulse, got.left_pulse);
          fail_count++;
        end
        if (got.right_pulse !== exp_w.right_pulse) begin
          $error("right_pulse exp %0d got %0d", exp_w.right_pulse, got.right_pulse);
          fail_count++;
        end
        if (got.left_duty !== exp_w.left_duty) begin
          $error("left_duty exp %0d got %0d", exp_w.left_duty, got.left_duty);
          fail_count++;
        end
        if (got.right_duty !== exp_w.right_duty) begin
          $error("right_duty exp %0d got %0d", exp_w.right_duty, got.right_duty);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [15:0] speed_near(int spread);
    longint s;
    s = regs[REG_TARGET] + $signed($urandom_range(0, 2 * spread)) - spread;
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return s[15:0];
  endfunction

  task automatic test_directed;
    send_period(16'd200, 16'd200, 3'b011);
    send_period(16'd0, 16'd0, 3'b011);
    send_period(16'hFFFF, 16'hFFFF, 3'b011);
    send_period(16'hFFFF, 16'd0, 3'b001);
    send_period(16'd0, 16'hFFFF, 3'b010);
    send_period(16'h5555, 16'hAAAA, 3'b000);
    send_period(16'd100, 16'd300, 3'b111);
    send_period(16'd250, 16'd150, 3'b100);
    repeat (6) send_period(16'd150, 16'd260, 3'b011);
    send_period(16'hAAAA, 16'h5555, 3'b111);
    drain();
  endtask

  task automatic test_settings(int n, int spread);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send_period(16'($urandom), 16'($urandom), 3'($urandom_range(0, 7)));
      else
        send_period(speed_near(spread), speed_near(spread),
                    {($urandom_range(0, 30) == 0), $urandom_range(0, 9) != 0,
                     $urandom_range(0, 9) != 0});
    end
    drain();
  endtask

  task automatic test_gain_extremes;
    write_reg(REG_TARGET, 16'hFFFF);
    write_reg(REG_LEFT_KP, 16'h03FF);
    write_reg(REG_LEFT_KI, 16'h03FF);
    write_reg(REG_LEFT_KD, 16'h03FF);
    write_reg(REG_RIGHT_KP, 16'd0);
    write_reg(REG_RIGHT_KI, 16'd0);
    write_reg(REG_RIGHT_KD, 16'd0);
    write_reg(REG_PERIOD, 16'hFFFF);
    stall_mode = 1;
    test_settings(150, 20000);
    write_reg(REG_TARGET, 16'd0);
    write_reg(REG_PERIOD, 16'd0);
    write_reg(REG_RIGHT_KP, 16'h03FF);
    write_reg(REG_RIGHT_KI, 16'h03FF);
    write_reg(REG_RIGHT_KD, 16'h03FF);
    stall_mode = 2;
    test_settings(150, 200);
  endtask

  task automatic test_random_settings;
    repeat (4) begin
      write_reg(REG_TARGET, REG_W'($urandom_range(0, 3000)));
      for (int r = 1; r < 7; r++)
        write_reg(r[IDX_W-1:0], REG_W'($urandom_range(0, 1023)));
      write_reg(REG_PERIOD, REG_W'($urandom));
      stall_mode = $urandom_range(0, 2);
      test_settings(145, $urandom_range(5, 400));
    end
  endtask

  task automatic test_backpressure;
    stall_mode = 0;
    hold_cycles = 3000;
    test_settings(60, 100);
  endtask

  initial begin
    regs = '{200, 250, 20, 30, 230, 20, 30, 11362};
    left_loop = '{0, 0, 0, LEFT_INIT_DUTY};
    right_loop = '{0, 0, 0, RIGHT_INIT_DUTY};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings(200, 300);
    test_gain_extremes();
    test_random_settings();
    test_backpressure();
    $display("covered %0d output words over default, extreme and random gains,",
             word_count);
    $display("with reload, per-wheel enables, receiver stalls and a long hold-off");
    if (fail_count == 0 && expected_words.size() == 0)
      $display("dual_wheel_speed_pid verification clean");
    else
      $display("dual_wheel_speed_pid verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("dual_wheel_speed_pid verification failed");
    $finish;
  end

endmodule

/* dual_wheel_speed_pid.f */
rtl/dwsp_pkg.sv
rtl/dwsp_serial_mac.sv
rtl/dual_wheel_speed_pid.sv
tb/sv/dual_wheel_speed_pid_tb.sv
